// ----- hw/rtl/nmea_field_extractor_assert.svh -----
// Assertion macros for the sentence parser RTL.
`ifndef NMEA_FIELD_EXTRACTOR_ASSERT_SVH
`define NMEA_FIELD_EXTRACTOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define NFE_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define NFE_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/nfe_pkg.sv -----
// Shared constants, types and helper functions of the sentence parser.
`default_nettype none
package nfe_pkg;

  localparam int COORD_MAX_CHARS       = 19;
  localparam int SPEED_MAX_CHARS       = 9;
  localparam int COURSE_MAX_CHARS      = 6;
  localparam int COORD_FRACTION_DIGITS = 5;
  localparam int RATE_FRACTION_DIGITS  = 3;

  localparam logic [31:0] POW10_TAB [10] = '{
    32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000,
    32'd1000000, 32'd10000000, 32'd100000000, 32'd1000000000
  };

  localparam logic [31:0] COORD_SCALE = POW10_TAB[COORD_FRACTION_DIGITS];
  localparam logic [31:0] MINS_K      = POW10_TAB[7 - COORD_FRACTION_DIGITS];
  localparam logic [31:0] DEG_SCALE   = 32'd10000000;
  localparam int FRAC_W = $clog2(COORD_SCALE);
  localparam int MINS_W = 30;
  localparam int DEG_W  = 54;
  localparam int RV_W   = 37;

  localparam logic [29:0] HI_CAP     = 30'd999999999;
  localparam logic [6:0]  LO_CAP     = 7'd99;
  localparam logic [30:0] RATE_CAP   = 31'd100000000;
  localparam logic [29:0] LAT_MAX    = 30'd999999999;
  localparam logic [30:0] LON_MAX    = 31'd1999999999;
  localparam logic [23:0] SPEED_MAX  = 24'd9999999;
  localparam logic [19:0] COURSE_MAX = 20'd999999;
  localparam logic [31:0] RECIP15    = 32'd286331154;

  localparam logic [2:0] CFG_TIME   = 3'd0;
  localparam logic [2:0] CFG_ENABLE = 3'd6;

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic [7:0] char_byte;
    logic       last;
    logic       is_digit;
    logic       is_point;
    logic       is_comma;
    logic [3:0] digit;
  } nfe_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } nfe_fifo_stat_t;

  typedef struct packed {
    logic [29:0]       hi;
    logic [6:0]        lo;
    logic [FRAC_W-1:0] frac;
    logic [2:0]        fd;
  } nfe_coord_t;

  typedef struct packed {
    logic [26:0] ip;
    logic [9:0]  frac;
    logic [1:0]  fd;
  } nfe_rate_t;

  typedef struct packed {
    logic [5:0][6:0] pairs;
    nfe_coord_t      lat;
    logic [7:0]      lat_hemi;
    nfe_coord_t      lon;
    logic [7:0]      lon_hemi;
    nfe_rate_t       speed;
    nfe_rate_t       course;
  } nfe_snap_t;

  typedef struct packed {
    logic [5:0][4:0] comma;
    logic [5:0]      enable;
  } nfe_cfg_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic [6:0] pair_value(input logic [7:0] a, input logic [7:0] b);
    logic [6:0] v;
    v = '0;
    if (is_digit(a)) begin
      if (is_digit(b)) begin
        v = 7'(a[3:0]) * 7'd10 + 7'(b[3:0]);
      end else begin
        v = 7'(a[3:0]);
      end
    end else if (a == CH_SPACE || (a >= CH_TAB && a <= CH_CR) || a == CH_PLUS) begin
      if (is_digit(b)) begin
        v = 7'(b[3:0]);
      end
    end
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/nmea_field_extractor.sv -----
// Top level of the byte-serial NMEA sentence field parser.
// Throughput: one character per cycle, unless output back-pressure (m_tready low) holds the parser.
// Result path: the result of a sentence, once its last character is accepted, passes through
// the queue, the parser snapshot, three conversion stages and the output register.
// Reset: synchronous and active high; clears the queue, the sentence state, the held
// values and the pipeline, and loads the default field positions and enables.
`default_nettype none
`include "nmea_field_extractor_assert.svh"
module nmea_field_extractor (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [7:0]   s_tdata,   // char_byte[7:0]
  input  wire logic         s_tlast,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // hours, minutes, seconds, day, month, year, latitude, lat_hemisphere, longitude,
  // lon_hemisphere, speed, course
  output logic [167:0]      m_tdata,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [5:0]   cfg_data
);

  nfe_pkg::nfe_fifo_stat_t fifo_stat;
  nfe_pkg::nfe_item_t      in_item;
  nfe_pkg::nfe_item_t      head;
  nfe_pkg::nfe_snap_t      snap;
  logic push, pop, adv, snap_valid;

  assign cfg_ready = 1'b1;

  nfe_front u_front (
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .fifo_stat (fifo_stat),
    .push      (push),
    .item      (in_item)
  );

  nfe_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (in_item),
    .pop       (pop),
    .head      (head),
    .stat      (fifo_stat)
  );

  nfe_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .head       (head),
    .head_valid (!fifo_stat.empty),
    .adv        (adv),
    .pop        (pop),
    .snap_valid (snap_valid),
    .snap       (snap)
  );

  nfe_conv u_conv (
    .clk        (clk),
    .rst        (rst),
    .snap_valid (snap_valid),
    .snap       (snap),
    .adv        (adv),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

  `NFE_ASSERT_IMP(a_lat_range, m_tvalid, m_tdata[71:42] <= 30'd999999999, "latitude out of range")
  `NFE_ASSERT_IMP(a_lon_range, m_tvalid, m_tdata[110:80] <= 31'd1999999999, "longitude out of range")
  `NFE_ASSERT_IMP(a_course_range, m_tvalid, m_tdata[162:143] <= 20'd999999, "course out of range")
  `NFE_ASSERT_NEXT(a_full_holds, fifo_stat.full && !pop, !s_tready, "queue lost its full state")

endmodule
`default_nettype wire

// ----- hw/rtl/nfe_front.sv -----
// Input side: accepts characters and classifies them for the queue.
`default_nettype none
module nfe_front (
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [7:0]        s_tdata,
  input  wire logic              s_tlast,
  input  wire nfe_pkg::nfe_fifo_stat_t fifo_stat,
  output logic                   push,
  output nfe_pkg::nfe_item_t     item
);

  assign s_tready = !fifo_stat.full;
  assign push     = s_tvalid && !fifo_stat.full;

  always_comb begin
    item.char_byte = s_tdata;
    item.last      = s_tlast;
    item.is_digit  = nfe_pkg::is_digit(s_tdata);
    item.is_point  = (s_tdata == nfe_pkg::CH_POINT);
    item.is_comma  = (s_tdata == nfe_pkg::CH_COMMA);
    item.digit     = s_tdata[3:0];
  end

endmodule
`default_nettype wire

// ----- hw/rtl/nfe_fifo.sv -----
// Short queue of classified items between the front and the parser.
`default_nettype none
module nfe_fifo (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire nfe_pkg::nfe_item_t push_item,
  input  wire logic               pop,
  output nfe_pkg::nfe_item_t      head,
  output nfe_pkg::nfe_fifo_stat_t stat
);

  nfe_pkg::nfe_item_t mem [nfe_pkg::FIFO_DEPTH];
  logic [nfe_pkg::PTR_W-1:0] wr_ptr;
  logic [nfe_pkg::PTR_W-1:0] rd_ptr;
  logic [nfe_pkg::PTR_W:0]   count;

  assign stat.full  = (count == (nfe_pkg::PTR_W+1)'(nfe_pkg::FIFO_DEPTH));
  assign stat.empty = (count == '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/nfe_back.sv -----
// Parser: comma counting, field accumulation, held values and the sentence snapshot.
`default_nettype none
module nfe_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [5:0]         cfg_data,
  input  wire nfe_pkg::nfe_item_t head,
  input  wire logic               head_valid,
  input  wire logic               adv,
  output logic                    pop,
  output logic                    snap_valid,
  output nfe_pkg::nfe_snap_t      snap
);

  nfe_pkg::nfe_cfg_t cfg;

  logic [5:0]          comma_count, comma_count_next;
  logic [1:0][2:0]     td_cnt, td_cnt_next;
  logic [1:0][4:0][7:0] td_buf, td_buf_next;
  logic [5:0][6:0]     held_pairs, held_pairs_next;
  nfe_pkg::nfe_coord_t held_coord [2];
  nfe_pkg::nfe_coord_t held_coord_next [2];
  logic [1:0][7:0]     held_hemi, held_hemi_next;
  nfe_pkg::nfe_rate_t  held_rate [2];
  nfe_pkg::nfe_rate_t  held_rate_next [2];

  nfe_pkg::nfe_coord_t co_acc [2];
  nfe_pkg::nfe_coord_t co_acc_next [2];
  logic [1:0][4:0]     co_pos, co_pos_next;
  logic [1:0]          co_point, co_point_next, co_stop, co_stop_next;
  logic [1:0]          co_hemi, co_hemi_next;
  nfe_pkg::nfe_rate_t  rt_acc [2];
  nfe_pkg::nfe_rate_t  rt_acc_next [2];
  logic [1:0][4:0]     rt_pos, rt_pos_next;
  logic [1:0]          rt_point, rt_point_next, rt_stop, rt_stop_next;

  assign pop = adv && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.comma  <= {5'd3, 5'd7, 5'd5, 5'd3, 5'd9, 5'd1};
      cfg.enable <= 6'd31;
    end else if (cfg_valid) begin
      if (cfg_index == nfe_pkg::CFG_ENABLE) begin
        cfg.enable <= cfg_data;
      end else if (cfg_index < nfe_pkg::CFG_ENABLE) begin
        cfg.comma[cfg_index - nfe_pkg::CFG_TIME] <= cfg_data[4:0];
      end
    end
  end

  always_comb begin
    logic [7:0]  c;
    logic [5:0]  k;
    logic [9:0]  t10;
    logic [3:0]  carry;
    logic [33:0] hi10;
    logic [30:0] ip10;
    comma_count_next = comma_count;
    td_cnt_next      = td_cnt;
    td_buf_next      = td_buf;
    held_pairs_next  = held_pairs;
    held_hemi_next   = held_hemi;
    co_pos_next      = co_pos;
    co_point_next    = co_point;
    co_stop_next     = co_stop;
    co_hemi_next     = co_hemi;
    rt_pos_next      = rt_pos;
    rt_point_next    = rt_point;
    rt_stop_next     = rt_stop;
    for (int q = 0; q < 2; q++) begin
      held_coord_next[q] = held_coord[q];
      held_rate_next[q]  = held_rate[q];
      co_acc_next[q]     = co_acc[q];
      rt_acc_next[q]     = rt_acc[q];
    end
    c     = head.char_byte;
    k     = '0;
    t10   = '0;
    carry = '0;
    hi10  = '0;
    ip10  = '0;
    if (pop) begin
      for (int t = 0; t < 2; t++) begin
        if (comma_count >= {1'b0, cfg.comma[t]} && td_cnt[t] < 3'd6) begin
          if (td_cnt[t] < 3'd5) begin
            td_buf_next[t][td_cnt[t]] = c;
          end
          td_cnt_next[t] = td_cnt[t] + 3'd1;
          if (td_cnt[t] == 3'd5 && cfg.enable[t]) begin
            held_pairs_next[3*t]   = nfe_pkg::pair_value(td_buf[t][0], td_buf[t][1]);
            held_pairs_next[3*t+1] = nfe_pkg::pair_value(td_buf[t][2], td_buf[t][3]);
            held_pairs_next[3*t+2] = nfe_pkg::pair_value(td_buf[t][4], c);
          end
        end
      end

      for (int q = 0; q < 2; q++) begin
        k = {1'b0, cfg.comma[2+q]};
        if (co_hemi[q]) begin
          co_hemi_next[q] = 1'b0;
          if (cfg.enable[2+q]) begin
            held_coord_next[q] = co_acc[q];
            held_hemi_next[q]  = c;
          end
        end
        if (comma_count == k) begin
          if (head.is_comma) begin
            if (head.last) begin
              if (cfg.enable[2+q]) begin
                held_coord_next[q] = co_acc[q];
                held_hemi_next[q]  = '0;
              end
            end else begin
              co_hemi_next[q] = 1'b1;
            end
          end else begin
            if (co_pos[q] < 5'(nfe_pkg::COORD_MAX_CHARS) && !co_stop[q]) begin
              if (head.is_digit) begin
                if (!co_point[q]) begin
                  t10   = 10'(co_acc[q].lo) * 10'd10 + 10'(head.digit);
                  carry = '0;
                  for (int i = 1; i < 10; i++) begin
                    if (t10 >= 10'(i * 100)) begin
                      carry = 4'(i);
                    end
                  end
                  hi10 = 34'(co_acc[q].hi) * 34'd10 + 34'(carry);
                  if (hi10 > 34'(nfe_pkg::HI_CAP)) begin
                    co_acc_next[q].hi = nfe_pkg::HI_CAP;
                    co_acc_next[q].lo = nfe_pkg::LO_CAP;
                  end else begin
                    co_acc_next[q].hi = hi10[29:0];
                    co_acc_next[q].lo = 7'(t10 - 10'(carry) * 10'd100);
                  end
                end else if (co_acc[q].fd < 3'(nfe_pkg::COORD_FRACTION_DIGITS)) begin
                  co_acc_next[q].frac = nfe_pkg::FRAC_W'(
                    co_acc[q].frac * nfe_pkg::FRAC_W'(10) + nfe_pkg::FRAC_W'(head.digit));
                  co_acc_next[q].fd = co_acc[q].fd + 3'd1;
                end
              end else if (head.is_point && !co_point[q]) begin
                co_point_next[q] = 1'b1;
              end else begin
                co_stop_next[q] = 1'b1;
              end
            end
            if (co_pos[q] != 5'd31) begin
              co_pos_next[q] = co_pos[q] + 5'd1;
            end
          end
        end
      end

      for (int r = 0; r < 2; r++) begin
        k = {1'b0, cfg.comma[4+r]};
        if (comma_count == k) begin
          if (head.is_comma) begin
            if (rt_pos[r] != '0 && cfg.enable[4+r]) begin
              held_rate_next[r] = rt_acc[r];
            end
          end else begin
            if (rt_pos[r] < 5'((r == 0) ? nfe_pkg::SPEED_MAX_CHARS : nfe_pkg::COURSE_MAX_CHARS)
                && !rt_stop[r]) begin
              if (head.is_digit) begin
                if (!rt_point[r]) begin
                  ip10 = 31'(rt_acc[r].ip) * 31'd10 + 31'(head.digit);
                  if (ip10 > nfe_pkg::RATE_CAP) begin
                    rt_acc_next[r].ip = 27'(nfe_pkg::RATE_CAP);
                  end else begin
                    rt_acc_next[r].ip = ip10[26:0];
                  end
                end else if (rt_acc[r].fd < 2'(nfe_pkg::RATE_FRACTION_DIGITS)) begin
                  rt_acc_next[r].frac = rt_acc[r].frac * 10'd10 + 10'(head.digit);
                  rt_acc_next[r].fd   = rt_acc[r].fd + 2'd1;
                end
              end else if (head.is_point && !rt_point[r]) begin
                rt_point_next[r] = 1'b1;
              end else begin
                rt_stop_next[r] = 1'b1;
              end
            end
            if (rt_pos[r] != 5'd31) begin
              rt_pos_next[r] = rt_pos[r] + 5'd1;
            end
            if (r == 1 && head.last && cfg.enable[5]) begin
              held_rate_next[r] = rt_acc_next[r];
            end
          end
        end
      end

      if (head.is_comma && comma_count != 6'd63) begin
        comma_count_next = comma_count + 6'd1;
      end

      if (head.last) begin
        comma_count_next = '0;
        td_cnt_next      = '0;
        co_pos_next      = '0;
        co_point_next    = '0;
        co_stop_next     = '0;
        co_hemi_next     = '0;
        rt_pos_next      = '0;
        rt_point_next    = '0;
        rt_stop_next     = '0;
        for (int q = 0; q < 2; q++) begin
          co_acc_next[q] = '0;
          rt_acc_next[q] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    td_buf <= td_buf_next;
    if (rst) begin
      comma_count <= '0;
      td_cnt      <= '0;
      held_pairs  <= '0;
      held_hemi   <= '0;
      co_pos      <= '0;
      co_point    <= '0;
      co_stop     <= '0;
      co_hemi     <= '0;
      rt_pos      <= '0;
      rt_point    <= '0;
      rt_stop     <= '0;
      for (int q = 0; q < 2; q++) begin
        held_coord[q] <= '0;
        held_rate[q]  <= '0;
        co_acc[q]     <= '0;
        rt_acc[q]     <= '0;
      end
    end else begin
      comma_count <= comma_count_next;
      td_cnt      <= td_cnt_next;
      held_pairs  <= held_pairs_next;
      held_hemi   <= held_hemi_next;
      co_pos      <= co_pos_next;
      co_point    <= co_point_next;
      co_stop     <= co_stop_next;
      co_hemi     <= co_hemi_next;
      rt_pos      <= rt_pos_next;
      rt_point    <= rt_point_next;
      rt_stop     <= rt_stop_next;
      for (int q = 0; q < 2; q++) begin
        held_coord[q] <= held_coord_next[q];
        held_rate[q]  <= held_rate_next[q];
        co_acc[q]     <= co_acc_next[q];
        rt_acc[q]     <= rt_acc_next[q];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (adv) begin
      snap_valid <= pop && head.last;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      snap.pairs    <= held_pairs_next;
      snap.lat      <= held_coord_next[0];
      snap.lat_hemi <= held_hemi_next[0];
      snap.lon      <= held_coord_next[1];
      snap.lon_hemi <= held_hemi_next[1];
      snap.speed    <= held_rate_next[0];
      snap.course   <= held_rate_next[1];
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/nfe_conv.sv -----
// Unit conversion pipeline and output register for the held sentence values.
`default_nettype none
module nfe_conv (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               snap_valid,
  input  wire nfe_pkg::nfe_snap_t snap,
  output logic                    adv,
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output logic [167:0]            m_tdata
);

  logic v1, v2, v3;

  logic [5:0][6:0]     s1_pairs, s2_pairs, s3_pairs, o_pairs;
  logic [1:0][7:0]     s1_hemi, s2_hemi, s3_hemi, o_hemi;
  logic [1:0][nfe_pkg::DEG_W-1:0]  s1_deg, s2_deg, s3_deg;
  logic [1:0][nfe_pkg::MINS_W-1:0] s1_mins, s2_y;
  logic [1:0][nfe_pkg::RV_W-1:0]   s1_rv;
  logic [1:0][27:0]    s3_n, s3_qe;
  logic [23:0]         s2_speed, s3_speed, o_speed;
  logic [19:0]         s2_course, s3_course, o_course;
  logic [29:0]         o_lat;
  logic [30:0]         o_lon;

  nfe_pkg::nfe_coord_t sc [2];
  nfe_pkg::nfe_rate_t  sr [2];

  logic [1:0][27:0]               qf;
  logic [1:0][nfe_pkg::DEG_W:0]   cv;

  assign adv      = !m_tvalid || m_tready;
  assign sc[0]    = snap.lat;
  assign sc[1]    = snap.lon;
  assign sr[0]    = snap.speed;
  assign sr[1]    = snap.course;
  assign m_tdata  = {5'b0, o_course, o_speed, o_hemi[1], o_lon, o_hemi[0], o_lat, o_pairs};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      v1       <= snap_valid;
      v2       <= v1;
      v3       <= v2;
      m_tvalid <= v3;
    end
  end

  always_comb begin
    for (int q = 0; q < 2; q++) begin
      if (32'(s3_qe[q]) * 32'd15 > 32'(s3_n[q])) begin
        qf[q] = s3_qe[q] - 28'd1;
      end else begin
        qf[q] = s3_qe[q];
      end
      cv[q] = (nfe_pkg::DEG_W+1)'(s3_deg[q]) + (nfe_pkg::DEG_W+1)'(qf[q]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pairs <= snap.pairs;
      s1_hemi  <= {snap.lon_hemi, snap.lat_hemi};
      for (int q = 0; q < 2; q++) begin
        s1_deg[q]  <= nfe_pkg::DEG_W'(64'(sc[q].hi) * 64'(nfe_pkg::DEG_SCALE));
        s1_mins[q] <= nfe_pkg::MINS_W'(64'(sc[q].lo) * 64'(nfe_pkg::COORD_SCALE)
                      + 64'(sc[q].frac) * 64'(nfe_pkg::POW10_TAB[
                        4'(nfe_pkg::COORD_FRACTION_DIGITS) - 4'(sc[q].fd)]));
        s1_rv[q]   <= nfe_pkg::RV_W'(64'(sr[q].ip) * 64'd1000
                      + 64'(sr[q].frac) * 64'(nfe_pkg::POW10_TAB[
                        4'(nfe_pkg::RATE_FRACTION_DIGITS) - 4'(sr[q].fd)]));
      end

      s2_pairs <= s1_pairs;
      s2_hemi  <= s1_hemi;
      s2_deg   <= s1_deg;
      for (int q = 0; q < 2; q++) begin
        s2_y[q] <= nfe_pkg::MINS_W'(64'(s1_mins[q]) * 64'(nfe_pkg::MINS_K));
      end
      s2_speed  <= (s1_rv[0] > nfe_pkg::RV_W'(nfe_pkg::SPEED_MAX)) ?
                   nfe_pkg::SPEED_MAX : s1_rv[0][23:0];
      s2_course <= (s1_rv[1] > nfe_pkg::RV_W'(nfe_pkg::COURSE_MAX)) ?
                   nfe_pkg::COURSE_MAX : s1_rv[1][19:0];

      s3_pairs  <= s2_pairs;
      s3_hemi   <= s2_hemi;
      s3_deg    <= s2_deg;
      s3_speed  <= s2_speed;
      s3_course <= s2_course;
      for (int q = 0; q < 2; q++) begin
        s3_n[q]  <= s2_y[q][nfe_pkg::MINS_W-1:2];
        s3_qe[q] <= 28'((64'(s2_y[q][nfe_pkg::MINS_W-1:2]) * 64'(nfe_pkg::RECIP15)) >> 32);
      end

      o_pairs  <= s3_pairs;
      o_hemi   <= s3_hemi;
      o_speed  <= s3_speed;
      o_course <= s3_course;
      o_lat    <= (cv[0] > (nfe_pkg::DEG_W+1)'(nfe_pkg::LAT_MAX)) ?
                  nfe_pkg::LAT_MAX : cv[0][29:0];
      o_lon    <= (cv[1] > (nfe_pkg::DEG_W+1)'(nfe_pkg::LON_MAX)) ?
                  nfe_pkg::LON_MAX : cv[1][30:0];
    end
  end

endmodule
`default_nettype wire
